// ----- hdl/sic_pkg.sv -----
// shared types and constants of the separable integer convolution
package sic_pkg;

  // default sizing of the top level
  localparam int DEF_MAX_TAPS  = 8;
  localparam int DEF_MAX_LINE  = 4096;
  localparam int DEF_MAX_BANDS = 4;

  // datapath and configuration port widths
  localparam int DATA_W  = 32;
  localparam int SCALE_W = 16;
  localparam int CFG_W   = 64;
  localparam int ADDR_W  = 6;

  // register map, one 64-bit slot per register
  typedef enum logic [2:0] {
    REG_TAP_COUNT,
    REG_KERNEL_SCALE,
    REG_KERNEL_OFFSET,
    REG_COEFF_LOW,
    REG_COEFF_HIGH,
    REG_LINE_ELEMENTS,
    REG_BAND_COUNT,
    REG_PIXEL_FORMAT
  } reg_idx_t;

  // pixel format codes
  typedef enum logic [2:0] {
    FMT_U8,
    FMT_S8,
    FMT_U16,
    FMT_S16,
    FMT_U32,
    FMT_S32
  } pix_fmt_t;

  // control bits that travel with each element down the pipeline
  typedef struct packed {
    logic produce;
    logic last;
  } side_t;

endpackage

// ----- hdl/sic_ram.sv -----
// generic single-write, single-read ram with registered read data
module sic_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write port and read-first registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/sic_dot.sv -----
// pipelined dot product of operands and taps, plus rounding half, wrapping at 32 bits
module sic_dot #(
  parameter int TAPS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [sic_pkg::DATA_W-1:0]  opnd [TAPS],
  input  logic [sic_pkg::DATA_W-1:0]  coef [TAPS],
  input  logic [sic_pkg::DATA_W-1:0]  half,
  input  sic_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [sic_pkg::DATA_W-1:0]  out_acc,
  output sic_pkg::side_t              out_side
);
  import sic_pkg::*;

  localparam int PAIRS = (TAPS + 1) / 2;

  logic              p_valid;
  logic [DATA_W-1:0] prod [TAPS];
  side_t             p_side;
  logic              s_valid;
  logic [DATA_W-1:0] psum [PAIRS];
  side_t             s_side;
  logic [DATA_W-1:0] total;

  // stage 1: products, low 32 bits kept
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= in_valid;
    end
    if (en) begin
      p_side <= in_side;
      for (int k = 0; k < TAPS; k++) begin
        prod[k] <= opnd[k] * coef[k];
      end
    end
  end

  // stage 2: pair sums
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (en) begin
      s_valid <= p_valid;
    end
    if (en) begin
      s_side <= p_side;
      for (int j = 0; j < PAIRS; j++) begin
        if (2 * j + 1 < TAPS) begin
          psum[j] <= prod[2 * j] + prod[2 * j + 1];
        end else begin
          psum[j] <= prod[2 * j];
        end
      end
    end
  end

  // final sum with rounding half
  always_comb begin
    total = half;
    for (int j = 0; j < PAIRS; j++) begin
      total = total + psum[j];
    end
  end

  // stage 3: accumulated result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s_valid;
    end
    if (en) begin
      out_side <= s_side;
      out_acc  <= total;
    end
  end

endmodule

// ----- hdl/sic_div.sv -----
// pipelined signed by unsigned divider, one quotient bit per stage, truncating toward zero
module sic_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [sic_pkg::DATA_W-1:0]  in_acc,
  input  logic [sic_pkg::SCALE_W-1:0] scale,
  input  sic_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [sic_pkg::DATA_W-1:0]  out_quot,
  output sic_pkg::side_t              out_side
);
  import sic_pkg::*;

  localparam int STEPS = DATA_W;

  logic               vld [STEPS+1];
  logic               neg [STEPS+1];
  logic [DATA_W-1:0]  dvd [STEPS+1];
  logic [SCALE_W-1:0] rem [STEPS+1];
  side_t              sd  [STEPS+1];

  // entry stage: sign and magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      neg[0] <= in_acc[DATA_W-1];
      dvd[0] <= in_acc[DATA_W-1] ? (~in_acc + DATA_W'(1)) : in_acc;
      rem[0] <= '0;
      sd[0]  <= in_side;
    end
  end

  // restoring steps, quotient bits shift in behind the dividend
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [SCALE_W:0] trial;
    logic             ge;
    assign trial = {rem[i], dvd[i][DATA_W-1]};
    assign ge    = trial >= {1'b0, scale};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        neg[i+1] <= neg[i];
        sd[i+1]  <= sd[i];
        dvd[i+1] <= {dvd[i][DATA_W-2:0], ge};
        rem[i+1] <= ge ? SCALE_W'(trial - {1'b0, scale}) : trial[SCALE_W-1:0];
      end
    end
  end

  // sign restore
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[STEPS];
    end
    if (en) begin
      out_side <= sd[STEPS];
      out_quot <= neg[STEPS] ? (~dvd[STEPS] + DATA_W'(1)) : dvd[STEPS];
    end
  end

endmodule

// ----- hdl/separable_int_convolution.sv -----
// top level of the separable two-pass integer convolution over a raster stream
// throughput: one element per cycle while no stall and no line store clearing holds the input;
// two 34-stage dividers and the line store port set the depth
// a stall on the result side holds every stage at once
// reset: synchronous; all MAX_LINE words of the line store are then cleared with s_tready low
module separable_int_convolution #(
  parameter int MAX_TAPS  = sic_pkg::DEF_MAX_TAPS,
  parameter int MAX_LINE  = sic_pkg::DEF_MAX_LINE,
  parameter int MAX_BANDS = sic_pkg::DEF_MAX_BANDS
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sic_pkg::ADDR_W-1:0]  paddr,
  input  logic [sic_pkg::CFG_W-1:0]   pwdata,
  output logic [sic_pkg::CFG_W-1:0]   prdata,
  output logic                        pready,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [31:0]                 s_tdata,  // sample_bits
  input  logic [0:0]                  s_tuser,  // frame_start
  // output stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,  // result_bits
  output logic [1:0]                  m_tuser,  // clipped_low, clipped_high
  output logic                        m_tlast   // line_last
);
  import sic_pkg::*;

  localparam int HIST_ROWS = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
  localparam int WIN_LEN   = MAX_TAPS * MAX_BANDS;
  localparam int HW        = HIST_ROWS * DATA_W;
  localparam int CW        = $clog2(MAX_LINE);
  localparam int LW        = $clog2(MAX_LINE + 1);
  localparam int NW        = $clog2(MAX_TAPS + 1);
  localparam int BW        = $clog2(MAX_BANDS + 1);
  localparam int WIX       = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;

  // configuration registers
  logic [3:0]         tap_count;
  logic [15:0]        kernel_scale;
  logic [15:0]        kernel_offset;
  logic [63:0]        coeff_pack_low;
  logic [63:0]        coeff_pack_high;
  logic [12:0]        line_elements;
  logic [2:0]         band_count;
  logic [2:0]         pixel_format;

  // settings after range limiting
  logic [NW-1:0]      n_eff;
  logic [BW-1:0]      b_eff;
  logic [LW-1:0]      len_eff;
  logic [SCALE_W-1:0] scale_eff;
  pix_fmt_t           fmt_eff;
  logic [WIX-1:0]     span;
  logic [WIX-1:0]     tap_dist [MAX_TAPS];
  logic [DATA_W-1:0]  coef [MAX_TAPS];
  logic [DATA_W-1:0]  half;
  logic [DATA_W-1:0]  off32;

  // flow control and line store clearing
  logic               adv;
  logic               acc_in;
  logic               clr_busy;
  logic [CW-1:0]      clr_addr;

  // position counters
  logic [CW-1:0]      colpos;
  logic [15:0]        rowpos;
  logic [LW-1:0]      c0;
  logic [LW-1:0]      cn;
  logic [15:0]        r0;
  logic [15:0]        rn;
  logic [DATA_W-1:0]  x_in;
  side_t              side_in;

  // stage a
  logic               a_valid;
  logic [DATA_W-1:0]  a_x;
  logic [CW-1:0]      a_c;
  side_t              a_side;

  // line store and forwarding of the latest write
  logic [HW-1:0]      ram_rdata;
  logic [HW-1:0]      hist_word;
  logic [HW-1:0]      new_word;
  logic               ram_we;
  logic [CW-1:0]      ram_waddr;
  logic [HW-1:0]      ram_wdata;
  logic               fw_valid;
  logic [CW-1:0]      fw_addr;
  logic [HW-1:0]      fw_data;

  // stage b: column pass operands
  logic               b_valid;
  logic [DATA_W-1:0]  b_opnd [MAX_TAPS];
  logic [DATA_W-1:0]  b_next [MAX_TAPS];
  side_t              b_side;

  // column pass
  logic               cd_valid;
  logic [DATA_W-1:0]  cd_acc;
  side_t              cd_side;
  logic               cv_valid;
  logic [DATA_W-1:0]  cv_quot;
  side_t              cv_side;

  // row window and row pass
  logic [DATA_W-1:0]  win [WIN_LEN];
  logic               r_valid;
  side_t              r_side;
  logic [DATA_W-1:0]  r_opnd [MAX_TAPS];
  logic               rd_valid;
  logic [DATA_W-1:0]  rd_acc;
  side_t              rd_side;
  logic               rv_valid;
  logic [DATA_W-1:0]  rv_quot;
  side_t              rv_side;

  // final stages
  logic               f_valid;
  logic [DATA_W-1:0]  f_s;
  side_t              f_side;
  logic [DATA_W-1:0]  clip_res;
  logic               clip_hi;
  logic               clip_lo;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count       <= 4'd3;
      kernel_scale    <= 16'd1;
      kernel_offset   <= '0;
      coeff_pack_low  <= '0;
      coeff_pack_high <= '0;
      line_elements   <= 13'd640;
      band_count      <= 3'd1;
      pixel_format    <= 3'd0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[5:3]))
        REG_TAP_COUNT:     tap_count       <= pwdata[3:0];
        REG_KERNEL_SCALE:  kernel_scale    <= pwdata[15:0];
        REG_KERNEL_OFFSET: kernel_offset   <= pwdata[15:0];
        REG_COEFF_LOW:     coeff_pack_low  <= pwdata;
        REG_COEFF_HIGH:    coeff_pack_high <= pwdata;
        REG_LINE_ELEMENTS: line_elements   <= pwdata[12:0];
        REG_BAND_COUNT:    band_count      <= pwdata[2:0];
        REG_PIXEL_FORMAT:  pixel_format    <= pwdata[2:0];
        default:           tap_count       <= tap_count;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx_t'(paddr[5:3]))
      REG_TAP_COUNT:     prdata = CFG_W'(tap_count);
      REG_KERNEL_SCALE:  prdata = CFG_W'(kernel_scale);
      REG_KERNEL_OFFSET: prdata = CFG_W'(kernel_offset);
      REG_COEFF_LOW:     prdata = coeff_pack_low;
      REG_COEFF_HIGH:    prdata = coeff_pack_high;
      REG_LINE_ELEMENTS: prdata = CFG_W'(line_elements);
      REG_BAND_COUNT:    prdata = CFG_W'(band_count);
      REG_PIXEL_FORMAT:  prdata = CFG_W'(pixel_format);
      default:           prdata = '0;
    endcase
  end

  // range limiting of the settings
  always_comb begin
    if (tap_count == '0) begin
      n_eff = NW'(1);
    end else if (int'(tap_count) > MAX_TAPS) begin
      n_eff = NW'(MAX_TAPS);
    end else begin
      n_eff = NW'(tap_count);
    end
    if (band_count == '0) begin
      b_eff = BW'(1);
    end else if (int'(band_count) > MAX_BANDS) begin
      b_eff = BW'(MAX_BANDS);
    end else begin
      b_eff = BW'(band_count);
    end
    if (line_elements == '0) begin
      len_eff = LW'(1);
    end else if (int'(line_elements) > MAX_LINE) begin
      len_eff = LW'(MAX_LINE);
    end else begin
      len_eff = LW'(line_elements);
    end
    scale_eff = (kernel_scale == '0) ? SCALE_W'(1) : kernel_scale;
    fmt_eff   = (pixel_format > FMT_S32) ? FMT_S32 : pix_fmt_t'(pixel_format);
    span      = WIX'((int'(n_eff) - 1) * int'(b_eff));
    for (int k = 0; k < MAX_TAPS; k++) begin
      if (k < int'(n_eff)) begin
        tap_dist[k] = WIX'((int'(n_eff) - 1 - k) * int'(b_eff));
      end else begin
        tap_dist[k] = '0;
      end
    end
    half  = DATA_W'(scale_eff >> 1);
    off32 = {{(DATA_W-16){kernel_offset[15]}}, kernel_offset};
  end

  // tap coefficients, sign extended; taps past the two packs weigh zero
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_coef
    if (k < 4) begin : g_low
      assign coef[k] = {{(DATA_W-16){coeff_pack_low[16*k+15]}}, coeff_pack_low[16*k +: 16]};
    end else if (k < 8) begin : g_high
      assign coef[k] = {{(DATA_W-16){coeff_pack_high[16*(k-4)+15]}},
                        coeff_pack_high[16*(k-4) +: 16]};
    end else begin : g_zero
      assign coef[k] = '0;
    end
  end

  // one global advance; the output register parts the two sides
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && !clr_busy;
  assign acc_in   = s_tvalid && s_tready;

  // line store clearing after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + CW'(1);
      if (clr_addr == CW'(MAX_LINE - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // column and row tracking for the incoming element
  always_comb begin
    c0 = s_tuser[0] ? '0 : LW'(colpos);
    r0 = s_tuser[0] ? '0 : rowpos;
    if (c0 >= len_eff) begin
      c0 = '0;
      if (r0 != 16'hFFFF) begin
        r0 = r0 + 16'd1;
      end
    end
    cn = c0 + LW'(1);
    rn = r0;
    if (cn >= len_eff) begin
      cn = '0;
      if (rn != 16'hFFFF) begin
        rn = rn + 16'd1;
      end
    end
    side_in.produce = (int'(r0) >= int'(n_eff) - 1) && (int'(c0) >= int'(span));
    side_in.last    = (c0 == len_eff - LW'(1));
  end

  // sample widening by format
  always_comb begin
    case (fmt_eff)
      FMT_U8:  x_in = {24'd0, s_tdata[7:0]};
      FMT_S8:  x_in = {{24{s_tdata[7]}}, s_tdata[7:0]};
      FMT_U16: x_in = {16'd0, s_tdata[15:0]};
      FMT_S16: x_in = {{16{s_tdata[15]}}, s_tdata[15:0]};
      default: x_in = s_tdata;
    endcase
  end

  // counters and stage a
  always_ff @(posedge clk) begin
    if (rst) begin
      colpos  <= '0;
      rowpos  <= '0;
      a_valid <= 1'b0;
    end else begin
      if (acc_in) begin
        colpos <= CW'(cn);
        rowpos <= rn;
      end
      if (adv) begin
        a_valid <= acc_in;
      end
    end
    if (adv) begin
      a_x    <= x_in;
      a_c    <= CW'(c0);
      a_side <= side_in;
    end
  end

  // column history, one word per column
  assign ram_we    = clr_busy || (a_valid && adv);
  assign ram_waddr = clr_busy ? clr_addr : a_c;
  assign ram_wdata = clr_busy ? '0 : new_word;

  sic_ram #(
    .W (HW),
    .D (MAX_LINE)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (adv),
    .raddr (CW'(c0)),
    .rdata (ram_rdata)
  );

  // history with the previous write forwarded, shifted word, column operands
  always_comb begin
    hist_word = (fw_valid && fw_addr == a_c) ? fw_data : ram_rdata;
    new_word  = hist_word;
    new_word[DATA_W-1:0] = a_x;
    for (int j = 1; j < HIST_ROWS; j++) begin
      new_word[j*DATA_W +: DATA_W] = hist_word[(j-1)*DATA_W +: DATA_W];
    end
    for (int k = 0; k < MAX_TAPS; k++) begin
      b_next[k] = '0;
      if (k < int'(n_eff) - 1) begin
        for (int j = 0; j < HIST_ROWS; j++) begin
          if (j == int'(n_eff) - 2 - k) begin
            b_next[k] = hist_word[j*DATA_W +: DATA_W];
          end
        end
      end else if (k == int'(n_eff) - 1) begin
        b_next[k] = a_x;
      end
    end
  end

  // forwarding register and stage b
  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
      b_valid  <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
      if (a_valid) begin
        fw_valid <= 1'b1;
      end
    end
    if (adv && a_valid) begin
      fw_addr <= a_c;
      fw_data <= new_word;
    end
    if (adv) begin
      b_side <= a_side;
      for (int k = 0; k < MAX_TAPS; k++) begin
        b_opnd[k] <= b_next[k];
      end
    end
  end

  // column pass sum and division
  sic_dot #(
    .TAPS (MAX_TAPS)
  ) u_col_dot (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (b_valid),
    .opnd      (b_opnd),
    .coef      (coef),
    .half      (half),
    .in_side   (b_side),
    .out_valid (cd_valid),
    .out_acc   (cd_acc),
    .out_side  (cd_side)
  );

  sic_div u_col_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (cd_valid),
    .in_acc    (cd_acc),
    .scale     (scale_eff),
    .in_side   (cd_side),
    .out_valid (cv_valid),
    .out_quot  (cv_quot),
    .out_side  (cv_side)
  );

  // row window: column sums of the most recent elements, newest at the front
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (adv) begin
      r_valid <= cv_valid;
    end
    if (adv) begin
      r_side <= cv_side;
    end
    if (adv && cv_valid) begin
      win[0] <= cv_quot + off32;
      for (int j = 1; j < WIN_LEN; j++) begin
        win[j] <= win[j-1];
      end
    end
  end

  // row operands at band stride
  always_comb begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      r_opnd[k] = '0;
      if (k < int'(n_eff)) begin
        for (int j = 0; j < WIN_LEN; j++) begin
          if (j == int'(tap_dist[k])) begin
            r_opnd[k] = win[j];
          end
        end
      end
    end
  end

  // row pass sum and division
  sic_dot #(
    .TAPS (MAX_TAPS)
  ) u_row_dot (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (r_valid),
    .opnd      (r_opnd),
    .coef      (coef),
    .half      (half),
    .in_side   (r_side),
    .out_valid (rd_valid),
    .out_acc   (rd_acc),
    .out_side  (rd_side)
  );

  sic_div u_row_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (rd_valid),
    .in_acc    (rd_acc),
    .scale     (scale_eff),
    .in_side   (rd_side),
    .out_valid (rv_valid),
    .out_quot  (rv_quot),
    .out_side  (rv_side)
  );

  // offset after the row division
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= rv_valid;
    end
    if (adv) begin
      f_s    <= rv_quot + off32;
      f_side <= rv_side;
    end
  end

  // clip to the pixel format
  always_comb begin
    clip_hi  = 1'b0;
    clip_lo  = 1'b0;
    clip_res = f_s;
    case (fmt_eff)
      FMT_U8: begin
        if ($signed(f_s) > 32'sd255) begin
          clip_hi  = 1'b1;
          clip_res = 32'd255;
        end else if (f_s[DATA_W-1]) begin
          clip_lo  = 1'b1;
          clip_res = '0;
        end else begin
          clip_res = {24'd0, f_s[7:0]};
        end
      end
      FMT_S8: begin
        if ($signed(f_s) > 32'sd127) begin
          clip_hi  = 1'b1;
          clip_res = 32'h7F;
        end else if ($signed(f_s) < -32'sd128) begin
          clip_lo  = 1'b1;
          clip_res = 32'h80;
        end else begin
          clip_res = {24'd0, f_s[7:0]};
        end
      end
      FMT_U16: begin
        if ($signed(f_s) > 32'sd65535) begin
          clip_hi  = 1'b1;
          clip_res = 32'hFFFF;
        end else if (f_s[DATA_W-1]) begin
          clip_lo  = 1'b1;
          clip_res = '0;
        end else begin
          clip_res = {16'd0, f_s[15:0]};
        end
      end
      FMT_S16: begin
        if ($signed(f_s) > 32'sd32767) begin
          clip_hi  = 1'b1;
          clip_res = 32'h7FFF;
        end else if ($signed(f_s) < -32'sd32768) begin
          clip_lo  = 1'b1;
          clip_res = 32'h8000;
        end else begin
          clip_res = {16'd0, f_s[15:0]};
        end
      end
      default: clip_res = f_s;
    endcase
  end

  // output register, only producing elements become beats
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= f_valid && f_side.produce;
    end
    if (adv) begin
      m_tdata <= clip_res;
      m_tuser <= {clip_lo, clip_hi};
      m_tlast <= f_side.last;
    end
  end

endmodule
